/* design/deadline_ordered_task_queue_unit_assert.svh */
// Assertion macros used by the checker file of the task queue.
`ifndef DEADLINE_ORDERED_TASK_QUEUE_UNIT_ASSERT_SVH
`define DEADLINE_ORDERED_TASK_QUEUE_UNIT_ASSERT_SVH

// Implication checked at every rising edge of i_clk outside reset.
`define DOTQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition in one cycle that must be followed by a condition in the next cycle.
`define DOTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dotq_pkg.sv */
package dotq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int DATA_W   = 16;
    localparam int OCC_W    = 5;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic compare;
        logic update;
    } t_dp_cmd;

endpackage

/* design/dotq_ctrl.sv */
module dotq_ctrl
    import dotq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_stall,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_UPD  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The block takes a new request only when idle and out of reset.
    assign o_in_stall    = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid   = (r_state == S_OUT);
    assign o_cmd.load    = (r_state == S_IDLE) && i_valid && i_rst_n;
    assign o_cmd.compare = (r_state == S_CMP);
    assign o_cmd.update  = (r_state == S_UPD);

endmodule

/* design/dotq_datapath.sv */
module dotq_datapath
    import dotq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [1:0]        i_command,
    input  logic [DATA_W-1:0] i_deadline,
    input  logic [DATA_W-1:0] i_task_id,
    output logic [1:0]        o_status,
    output logic [DATA_W-1:0] o_out_deadline,
    output logic [DATA_W-1:0] o_out_id,
    output logic [OCC_W-1:0]  o_occupancy
);

    // Cell array in queue order; only cells below the count are meaningful.
    logic [DATA_W-1:0] r_cell_dl [CAPACITY];
    logic [DATA_W-1:0] r_cell_id [CAPACITY];
    logic [DATA_W-1:0] n_cell_dl [CAPACITY];
    logic [DATA_W-1:0] n_cell_id [CAPACITY];
    logic [DATA_W-1:0] left_dl   [CAPACITY];
    logic [DATA_W-1:0] left_id   [CAPACITY];
    logic [DATA_W-1:0] right_dl  [CAPACITY];
    logic [DATA_W-1:0] right_id  [CAPACITY];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    // Captured request.
    logic [1:0]        r_cmd;
    logic [DATA_W-1:0] r_dl;
    logic [DATA_W-1:0] r_id;

    // Compare stage results.
    logic [CAPACITY-1:0] r_lt;
    logic [CAPACITY-1:0] r_match;
    logic                r_eq_last;
    logic                r_gt_first;
    logic [CAPACITY-1:0] n_lt;
    logic [CAPACITY-1:0] n_match;
    logic                n_eq_last;
    logic                n_gt_first;
    logic [IDX_W-1:0]    last_idx;

    // Update stage.
    logic [CNT_W-1:0]  ins_pos;
    logic [IDX_W-1:0]  rem_pos;
    logic [IDX_W-1:0]  rpos;
    logic              found;
    logic              do_ins;
    logic              do_rem;
    logic [1:0]        n_status;
    logic [DATA_W-1:0] n_odl;
    logic [DATA_W-1:0] n_oid;

    // Result registers.
    logic [1:0]        r_status;
    logic [DATA_W-1:0] r_odl;
    logic [DATA_W-1:0] r_oid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_dl  <= i_deadline;
            r_id  <= i_task_id;
        end
    end

    assign last_idx = IDX_W'(r_count - CNT_W'(1));

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_lt[i]    = (CNT_W'(i) < r_count) && (r_cell_dl[i] < r_dl);
            n_match[i] = (CNT_W'(i) < r_count) && (r_cell_id[i] == r_id);
        end
        n_eq_last  = (r_count != '0) && (r_dl == r_cell_dl[last_idx]);
        n_gt_first = (r_dl > r_cell_dl[0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_lt       <= n_lt;
            r_match    <= n_match;
            r_eq_last  <= n_eq_last;
            r_gt_first <= n_gt_first;
        end
    end

    // Neighbor taps for shifting toward the tail (insert) or the head (remove).
    for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
        if (g == 0) begin : g_head
            assign left_dl[g] = r_dl;
            assign left_id[g] = r_id;
        end else begin : g_mid
            assign left_dl[g] = r_cell_dl[g-1];
            assign left_id[g] = r_cell_id[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign right_dl[g] = r_cell_dl[g];
            assign right_id[g] = r_cell_id[g];
        end else begin : g_body
            assign right_dl[g] = r_cell_dl[g+1];
            assign right_id[g] = r_cell_id[g+1];
        end
    end

    always_comb begin
        // Valid cells below the new deadline form a prefix, so its length is the slot.
        ins_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (r_lt[i]) begin
                ins_pos = CNT_W'(i + 1);
            end
        end
        // A deadline tying the tail and above the head goes behind the tail.
        if (r_eq_last && r_gt_first) begin
            ins_pos = r_count;
        end

        found   = 1'b0;
        rem_pos = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                found   = 1'b1;
                rem_pos = IDX_W'(i);
            end
        end

        do_ins   = 1'b0;
        do_rem   = 1'b0;
        rpos     = '0;
        n_status = ST_DONE;
        case (r_cmd)
            CMD_INSERT: begin
                if (r_count >= CNT_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            CMD_FINISH: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    do_rem = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (!found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    do_rem = 1'b1;
                    rpos   = rem_pos;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase

        n_odl   = do_rem ? r_cell_dl[rpos] : '0;
        n_oid   = do_rem ? r_cell_id[rpos] : '0;
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rem) begin
            n_count = r_count - CNT_W'(1);
        end

        for (int i = 0; i < CAPACITY; i++) begin
            n_cell_dl[i] = r_cell_dl[i];
            n_cell_id[i] = r_cell_id[i];
            if (do_ins) begin
                if (CNT_W'(i) == ins_pos) begin
                    n_cell_dl[i] = r_dl;
                    n_cell_id[i] = r_id;
                end else if (CNT_W'(i) > ins_pos) begin
                    n_cell_dl[i] = left_dl[i];
                    n_cell_id[i] = left_id[i];
                end
            end else if (do_rem && (CNT_W'(i) >= CNT_W'(rpos))) begin
                n_cell_dl[i] = right_dl[i];
                n_cell_id[i] = right_id[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_cell_dl <= n_cell_dl;
            r_cell_id <= n_cell_id;
            r_status  <= n_status;
            r_odl     <= n_odl;
            r_oid     <= n_oid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.update) begin
            r_count <= n_count;
        end
    end

    assign o_status       = r_status;
    assign o_out_deadline = r_odl;
    assign o_out_id       = r_oid;
    assign o_occupancy    = OCC_W'(r_count);

endmodule

/* design/deadline_ordered_task_queue_unit.sv */
// A request is captured on acceptance and passes the compare and update states before its
// result is presented; a new request is taken only after that result has been handed off.
// The compare pass and the shift pass work over the 16-cell array.
// Reset (synchronous, active low) empties the queue and returns the controller to idle.
// Cell contents are not cleared by reset; cells beyond the count never affect a result.
module deadline_ordered_task_queue_unit
    import dotq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_command,
    input  logic [DATA_W-1:0] i_deadline,
    input  logic [DATA_W-1:0] i_task_id,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic [DATA_W-1:0] o_out_deadline,
    output logic [DATA_W-1:0] o_out_id,
    output logic [OCC_W-1:0]  o_occupancy
);

    // The controller steps each request through capture, compare, update and
    // result hand-off. The datapath holds the sorted cells and the count.
    t_dp_cmd dp_cmd;

    dotq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_stall     (i_stall),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .o_cmd       (dp_cmd)
    );

    // In the compare cycle every cell checks its deadline against the new one
    // and its id against the requested id. In the update cycle the insert slot
    // or the first match is located and each cell loads itself, its left
    // neighbor, its right neighbor or the new task, so the array stays sorted.
    dotq_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_command      (i_command),
        .i_deadline     (i_deadline),
        .i_task_id      (i_task_id),
        .o_status       (o_status),
        .o_out_deadline (o_out_deadline),
        .o_out_id       (o_out_id),
        .o_occupancy    (o_occupancy)
    );

endmodule

/* design/dotq_checker.sv */
`include "deadline_ordered_task_queue_unit_assert.svh"

module dotq_checker
    import dotq_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic [1:0]        i_command,
    input logic [DATA_W-1:0] i_deadline,
    input logic [DATA_W-1:0] i_task_id,
    input logic              o_valid,
    input logic              i_stall,
    input logic [1:0]        o_status,
    input logic [DATA_W-1:0] o_out_deadline,
    input logic [DATA_W-1:0] o_out_id,
    input logic [OCC_W-1:0]  o_occupancy
);

    // A stalled result stays in place.
    `DOTQ_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_out_deadline) && $stable(o_out_id) && $stable(o_occupancy), "stalled result changed")

    // One request at a time: right after an accept the input side is stalled.
    `DOTQ_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "request accepted while busy")

    // A full report only comes from a full queue.
    `DOTQ_ASSERT_IMPL(a_full_count, o_valid && (o_status == ST_FULL), o_occupancy == OCC_W'(CAPACITY), "full status with room left")

    // An empty report only comes from an empty queue.
    `DOTQ_ASSERT_IMPL(a_empty_count, o_valid && (o_status == ST_EMPTY), o_occupancy == '0, "empty status with tasks held")

    // Only a successful removal carries a task.
    `DOTQ_ASSERT_IMPL(a_zero_payload, o_valid && (o_status != ST_DONE), (o_out_deadline == '0) && (o_out_id == '0), "task returned with a failure status")

endmodule

bind deadline_ordered_task_queue_unit dotq_checker u_dotq_checker (.*);

/* tb/sv/deadline_ordered_task_queue_unit_checker.sv */
`timescale 1ns / 1ps

module deadline_ordered_task_queue_unit_checker
    import dotq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              o_stall,
    input  logic [1:0]        i_command,
    input  logic [DATA_W-1:0] i_deadline,
    input  logic [DATA_W-1:0] i_task_id,
    input  logic              o_valid,
    input  logic              i_stall,
    input  logic [1:0]        o_status,
    input  logic [DATA_W-1:0] o_out_deadline,
    input  logic [DATA_W-1:0] o_out_id,
    input  logic [OCC_W-1:0]  o_occupancy,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] deadline;
        logic [DATA_W-1:0] task_id;
        logic [OCC_W-1:0]  occupancy;
    } task_result_t;

    // Shadow copy of the sorted cells; only entries below held are meaningful.
    logic [DATA_W-1:0] cell_deadline [CAPACITY];
    logic [DATA_W-1:0] cell_id       [CAPACITY];
    int                held = 0;

    task_result_t awaited_results [$];
    int           fail_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void drop_cell(int pos);
        for (int i = pos; i + 1 < held; i++) begin
            cell_deadline[i] = cell_deadline[i + 1];
            cell_id[i]       = cell_id[i + 1];
        end
        held--;
    endfunction

    function automatic task_result_t apply_command(logic [1:0] cmd, logic [DATA_W-1:0] dl,
                                                   logic [DATA_W-1:0] tid);
        task_result_t res;
        int           pos;
        res = '0;
        res.status = ST_DONE;
        case (cmd)
            CMD_INSERT: begin
                if (held >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < held && cell_deadline[pos] < dl) pos++;
                    // A tie with the tail goes behind it, unless the whole queue shares it.
                    if (held > 0 && dl == cell_deadline[held - 1] && dl > cell_deadline[0])
                        pos = held;
                    for (int i = held; i > pos; i--) begin
                        cell_deadline[i] = cell_deadline[i - 1];
                        cell_id[i]       = cell_id[i - 1];
                    end
                    cell_deadline[pos] = dl;
                    cell_id[pos]       = tid;
                    held++;
                end
            end
            CMD_FINISH: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.deadline = cell_deadline[0];
                    res.task_id  = cell_id[0];
                    drop_cell(0);
                end
            end
            CMD_REMOVE: begin
                if (held == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    pos = 0;
                    while (pos < held && cell_id[pos] != tid) pos++;
                    if (pos >= held) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        res.deadline = cell_deadline[pos];
                        res.task_id  = cell_id[pos];
                        drop_cell(pos);
                    end
                end
            end
            default: begin
            end
        endcase
        res.occupancy = OCC_W'(held);
        return res;
    endfunction

    always @(posedge i_clk) begin
        task_result_t want;
        task_result_t got;
        if (!i_rst_n) begin
            held = 0;
            awaited_results.delete();
        end else begin
            if (o_valid && !i_stall) begin
                got = {o_status, o_out_deadline, o_out_id, o_occupancy};
                if (awaited_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%0t: result with no request waiting: status %0d deadline %h id %h occupancy %0d",
                                 $time, got.status, got.deadline, got.task_id, got.occupancy);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status || got.deadline !== want.deadline ||
                        got.task_id !== want.task_id || got.occupancy !== want.occupancy) begin
                        fail_total++;
                        if (fail_total <= 10)
                            $display("%0t: mismatch: expected status %0d deadline %h id %h occupancy %0d, got status %0d deadline %h id %h occupancy %0d",
                                     $time, want.status, want.deadline, want.task_id,
                                     want.occupancy, got.status, got.deadline, got.task_id,
                                     got.occupancy);
                    end
                end
            end
            if (i_valid && !o_stall)
                awaited_results.push_back(apply_command(i_command, i_deadline, i_task_id));
        end
        o_fail_count <= fail_total;
        o_pending    <= awaited_results.size();
    end

endmodule

/* tb/sv/deadline_ordered_task_queue_unit_test.sv */
`timescale 1ns / 1ps

module deadline_ordered_task_queue_unit_test;
    import dotq_pkg::*;

    // The fourth command code has no meaning; the queue must answer it and change nothing.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Number of counted random requests after the directed part.
    localparam int RANDOM_REQUESTS = 500;
    // Cycles without any accepted request or result before the run is declared hung.
    localparam int WATCHDOG_LIMIT  = 2000;
    // Settling time after the last result.
    localparam int TAIL_CYCLES     = 20;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } traffic_mode_e;

    // Every input of the block starts at a known value.
    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_valid    = 1'b0;
    logic [1:0]        i_command  = CMD_INSERT;
    logic [DATA_W-1:0] i_deadline = '0;
    logic [DATA_W-1:0] i_task_id  = '0;
    logic              i_stall    = 1'b0;

    logic              o_stall;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [DATA_W-1:0] o_out_deadline;
    logic [DATA_W-1:0] o_out_id;
    logic [OCC_W-1:0]  o_occupancy;

    int fail_count;
    int pending_results;

    deadline_ordered_task_queue_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_deadline     (i_deadline),
        .i_task_id      (i_task_id),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_out_deadline (o_out_deadline),
        .o_out_id       (o_out_id),
        .o_occupancy    (o_occupancy)
    );

    // The checker watches both channels, keeps its own model of the queue and
    // reports back how many results went wrong and how many are still owed.
    deadline_ordered_task_queue_unit_checker queue_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_deadline     (i_deadline),
        .i_task_id      (i_task_id),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_out_deadline (o_out_deadline),
        .o_out_id       (o_out_id),
        .o_occupancy    (o_occupancy),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls on a pattern that switches now and then between no
    // back-pressure, light and heavy random stalling, and a regular square wave.
    int stall_mode = 0;
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 120);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 99) < 30);
            2:       i_stall <= ($urandom_range(0, 99) < 80);
            default: i_stall <= ((stall_left % 8) < 3);
        endcase
    end

    // The watchdog ends a run in which neither a request nor a result moves
    // for too long. Reset lasts far fewer cycles than the limit.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("deadline_ordered_task_queue_unit_test NOT OK");
                $finish;
            end
        end
    end

    // Presents one request and holds it, unchanged, until the queue takes it.
    // Valid is left high so that a burst can follow without a gap.
    task automatic send_request(input logic [1:0] cmd, input logic [DATA_W-1:0] dl,
                                input logic [DATA_W-1:0] tid);
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_deadline <= dl;
        i_task_id  <= tid;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic idle_for(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Holds off the sender until every owed result has come back. The first
    // cycle lets the checker count the request that was accepted last.
    task automatic drain_results;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    initial begin
        traffic_mode_e     mode;
        int                mode_left;
        int                burst_left;
        int                requests_sent;
        int                insert_share;
        int                pick;
        logic [1:0]        cmd;
        logic [DATA_W-1:0] dl;
        logic [DATA_W-1:0] tid;

        mode          = MODE_MIX;
        mode_left     = 0;
        burst_left    = 0;
        requests_sent = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Commands against an empty queue come first.
        send_request(CMD_FINISH, 16'h0000, 16'h0000);
        send_request(CMD_REMOVE, 16'h0000, 16'h0000);
        send_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
        // A first task, then one with the same deadline: with the whole queue at
        // one deadline the newcomer goes ahead of the equal entry.
        send_request(CMD_INSERT, 16'd100, 16'd1);
        send_request(CMD_INSERT, 16'd100, 16'd2);
        send_request(CMD_INSERT, 16'd50, 16'd3);
        // Equal to the tail and later than the head, so it goes last.
        send_request(CMD_INSERT, 16'd100, 16'd4);
        // Extremes of both fields, then an insertion into the middle.
        send_request(CMD_INSERT, 16'h0000, 16'h0000);
        send_request(CMD_INSERT, 16'hFFFF, 16'hFFFF);
        send_request(CMD_INSERT, 16'd75, 16'd5);
        // Equal to an inner entry only: goes ahead of the first equal one.
        send_request(CMD_INSERT, 16'd50, 16'd4);
        send_request(CMD_REMOVE, 16'h0000, 16'h1234);
        send_request(CMD_REMOVE, 16'hAAAA, 16'd2);
        // Two entries carry id 4; only the first in queue order is removed.
        send_request(CMD_REMOVE, 16'h5555, 16'd4);
        send_request(CMD_REMOVE, 16'h0000, 16'hFFFF);
        send_request(CMD_UNUSED, 16'h5A5A, 16'hA5A5);
        send_request(CMD_FINISH, 16'hFFFF, 16'hFFFF);
        send_request(CMD_FINISH, 16'h0000, 16'h0000);

        // Let everything come back once before the random traffic starts.
        drain_results();

        // Random part. Traffic runs in phases of random length that mostly fill
        // the queue, mostly drain it, or mix both. Small pools of deadlines
        // and ids make ties and successful removals common.
        while (requests_sent < RANDOM_REQUESTS) begin
            if (mode_left == 0) begin
                mode      = traffic_mode_e'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 60);
            end
            mode_left--;

            case (mode)
                MODE_FILL:  insert_share = 80;
                MODE_DRAIN: insert_share = 15;
                default:    insert_share = 45;
            endcase

            pick = $urandom_range(0, 99);
            if (pick < 3)
                cmd = CMD_UNUSED;
            else if (pick < 3 + insert_share)
                cmd = CMD_INSERT;
            else if ($urandom_range(0, 1) == 0)
                cmd = CMD_FINISH;
            else
                cmd = CMD_REMOVE;

            pick = $urandom_range(0, 99);
            if (pick < 40)
                dl = DATA_W'($urandom_range(0, 7));
            else if (pick < 55)
                dl = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
            else
                dl = DATA_W'($urandom_range(0, 65535));

            pick = $urandom_range(0, 99);
            if (pick < 60)
                tid = DATA_W'($urandom_range(0, 11));
            else if (pick < 70)
                tid = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
            else
                tid = DATA_W'($urandom_range(0, 65535));

            send_request(cmd, dl, tid);
            if (cmd != CMD_UNUSED)
                requests_sent++;

            // Bursts of random length separated by random gaps; now and then
            // the sender waits for the queue to go quiet altogether.
            if ($urandom_range(0, 99) == 0) begin
                drain_results();
            end else if (burst_left == 0) begin
                idle_for($urandom_range(1, 10));
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_results == 0) begin
            $display("deadline_ordered_task_queue_unit_test OK");
        end else begin
            $display("deadline_ordered_task_queue_unit_test NOT OK");
        end
        $finish;
    end

endmodule
